@@ design/els_pkg.sv @@
// ----------------------------------------------------------------------------
// els_pkg
// Shared types and constants for the LOOK elevator scheduler.
// ----------------------------------------------------------------------------
package els_pkg;

  localparam int unsigned FLOORS  = 16;
  localparam int unsigned FLOOR_W = 5;
  localparam int unsigned IDX_W   = $clog2(FLOORS);

  typedef logic [FLOORS-1:0]  calls_t;
  typedef logic [FLOOR_W-1:0] floor_t;
  typedef logic [IDX_W-1:0]   idx_t;

  typedef enum logic [2:0] {
    ACT_CABIN = 3'd0,
    ACT_HALL  = 3'd1,
    ACT_POS   = 3'd2,
    ACT_STOP  = 3'd3,
    ACT_EVAL  = 3'd4
  } els_action_e;

  typedef enum logic [1:0] {
    DIR_STILL = 2'd0,
    DIR_UP    = 2'd1,
    DIR_DOWN  = 2'd2
  } els_dir_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_APPLY,
    ST_SCAN_A,
    ST_SCAN_B,
    ST_DONE
  } els_state_e;

  // running results of the floor scans
  typedef struct packed {
    floor_t best;
    floor_t bestd;
    logic   found;
    floor_t limit;
    floor_t nt;
    logic   behind;
  } els_acc_t;

  // one floor presented to the evaluation unit
  typedef struct packed {
    logic   scan_b;
    floor_t flr;
    logic   cab;
    logic   up;
    logic   dn;
  } els_probe_t;

endpackage

@@ design/elevator_look_scheduler_unit.sv @@
// ----------------------------------------------------------------------------
// elevator_look_scheduler_unit
// Single-car LOOK elevator scheduler with per-floor call bits.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low. In-range cabin and
// hall calls, stops and re-evaluations run two scans over all floors through one
// shared compare unit, one floor per cycle: busy stays high through the scans and
// the DONE state, and done_o pulses in the cycle after. Position updates and
// ignored transactions (unknown actions, calls out of range) skip the scans. The
// result is on the outputs for the one cycle that done_o is high and must be
// taken then; a new transaction may start in that same cycle.
module elevator_look_scheduler_unit (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start,
  output logic                 busy,
  input  logic [2:0]           action_i,
  input  els_pkg::floor_t      floor_i,
  input  logic                 call_dir_i,
  output logic                 done_o,
  output els_pkg::floor_t      dest_floor_o,
  output logic [1:0]           travel_dir_o,
  output els_pkg::floor_t      travel_limit_o,
  output logic                 target_changed_o,
  output logic                 pending_any_o
);
  import els_pkg::*;

  els_state_e state_q, state_d;
  logic [2:0] action_q, action_d;
  floor_t     floor_q, floor_d;
  logic       cdir_q, cdir_d;
  calls_t     cab_q, cab_d;
  calls_t     up_q, up_d;
  calls_t     dn_q, dn_d;
  floor_t     pos_q, pos_d;
  floor_t     target_q, target_d;
  floor_t     limit_q, limit_d;
  els_dir_e   dir_q, dir_d;
  els_acc_t   acc_q, acc_d;
  idx_t       idx_q, idx_d;
  logic       done_q, done_d;
  logic       changed_q, changed_d;

  logic       floor_ok;
  logic       sched;
  logic       is_call;
  logic       last_idx;
  logic       all_any;
  calls_t     fbit;
  calls_t     pbit;
  els_probe_t probe;
  els_acc_t   eval_acc;

  assign floor_ok = (floor_q >= floor_t'(1)) && (floor_q <= floor_t'(FLOORS));
  assign is_call  = (action_q == ACT_CABIN) || (action_q == ACT_HALL);
  assign sched    = (is_call && floor_ok) || (action_q == ACT_STOP) ||
                    (action_q == ACT_EVAL);
  assign fbit     = floor_ok ? (calls_t'(1) << (floor_q - floor_t'(1))) : '0;
  assign pbit     = calls_t'(1) << (pos_q - floor_t'(1));
  assign last_idx = idx_q == idx_t'(FLOORS - 1);
  assign all_any  = |(cab_q | up_q | dn_q);

  assign probe.scan_b = (state_q == ST_SCAN_B);
  assign probe.flr    = floor_t'(idx_q) + floor_t'(1);
  assign probe.cab    = cab_q[idx_q];
  assign probe.up     = up_q[idx_q];
  assign probe.dn     = dn_q[idx_q];

  els_floor_eval u_eval (
    .probe_i (probe),
    .dir_i   (dir_q),
    .pos_i   (pos_q),
    .acc_i   (acc_q),
    .acc_o   (eval_acc)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (start) state_d = ST_APPLY;
      ST_APPLY:  state_d = sched ? ST_SCAN_A : ST_DONE;
      ST_SCAN_A: if (last_idx) state_d = ST_SCAN_B;
      ST_SCAN_B: if (last_idx) state_d = ST_DONE;
      ST_DONE:   state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    action_d  = action_q;
    floor_d   = floor_q;
    cdir_d    = cdir_q;
    cab_d     = cab_q;
    up_d      = up_q;
    dn_d      = dn_q;
    pos_d     = pos_q;
    target_d  = target_q;
    limit_d   = limit_q;
    dir_d     = dir_q;
    acc_d     = acc_q;
    idx_d     = idx_q;
    done_d    = 1'b0;
    changed_d = changed_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          action_d = action_i;
          floor_d  = floor_i;
          cdir_d   = call_dir_i;
        end
      end
      ST_APPLY: begin
        case (action_q)
          ACT_CABIN: begin
            cab_d = cab_q | fbit;
            if (floor_ok && dir_q == DIR_UP && floor_q > limit_q && floor_q > pos_q) begin
              limit_d = floor_q;
            end else if (floor_ok && dir_q == DIR_DOWN && floor_q < limit_q &&
                         floor_q < pos_q) begin
              limit_d = floor_q;
            end
          end
          ACT_HALL: begin
            if (cdir_q) dn_d = dn_q | fbit;
            else        up_d = up_q | fbit;
          end
          ACT_POS: begin
            if (floor_ok) pos_d = floor_q;
          end
          ACT_STOP: begin
            cab_d = cab_q & ~pbit;
            unique case (dir_q)
              DIR_UP: begin
                up_d = up_q & ~pbit;
                if (pos_q == limit_q) dn_d = dn_q & ~pbit;
              end
              DIR_DOWN: begin
                dn_d = dn_q & ~pbit;
                if (pos_q == limit_q) up_d = up_q & ~pbit;
              end
              default: begin
                up_d = up_q & ~pbit;
                dn_d = dn_q & ~pbit;
              end
            endcase
          end
          default: ;
        endcase
        acc_d.best   = '0;
        acc_d.bestd  = '0;
        acc_d.found  = 1'b0;
        acc_d.limit  = limit_d;
        acc_d.nt     = limit_d;
        acc_d.behind = 1'b0;
        idx_d        = '0;
      end
      ST_SCAN_A: begin
        acc_d = eval_acc;
        idx_d = idx_q + idx_t'(1);
        if (last_idx) begin
          acc_d.nt = eval_acc.limit;
          idx_d    = '0;
        end
      end
      ST_SCAN_B: begin
        acc_d = eval_acc;
        idx_d = last_idx ? '0 : idx_q + idx_t'(1);
      end
      ST_DONE: begin
        done_d = 1'b1;
        if (sched) begin
          if (!all_any) begin
            dir_d = DIR_STILL;
          end else if (dir_q == DIR_STILL) begin
            dir_d    = (acc_q.best > pos_q) ? DIR_UP : DIR_DOWN;
            limit_d  = acc_q.best;
            target_d = acc_q.best;
          end else begin
            limit_d  = acc_q.limit;
            target_d = acc_q.nt;
            if (pos_q == acc_q.limit && pos_q == target_q && pos_q == acc_q.nt) begin
              if (acc_q.behind) dir_d = (dir_q == DIR_UP) ? DIR_DOWN : DIR_UP;
              else              dir_d = DIR_STILL;
            end
          end
        end
        changed_d = is_call && sched && (target_d != target_q);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      cab_q     <= '0;
      up_q      <= '0;
      dn_q      <= '0;
      pos_q     <= floor_t'(1);
      target_q  <= floor_t'(1);
      limit_q   <= floor_t'(1);
      dir_q     <= DIR_STILL;
      idx_q     <= '0;
      done_q    <= 1'b0;
      changed_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      cab_q     <= cab_d;
      up_q      <= up_d;
      dn_q      <= dn_d;
      pos_q     <= pos_d;
      target_q  <= target_d;
      limit_q   <= limit_d;
      dir_q     <= dir_d;
      idx_q     <= idx_d;
      done_q    <= done_d;
      changed_q <= changed_d;
    end
  end

  always_ff @(posedge clk_i) begin
    action_q <= action_d;
    floor_q  <= floor_d;
    cdir_q   <= cdir_d;
    acc_q    <= acc_d;
  end

  assign busy             = (state_q != ST_IDLE);
  assign done_o           = done_q;
  assign dest_floor_o     = target_q;
  assign travel_dir_o     = dir_q;
  assign travel_limit_o   = limit_q;
  assign target_changed_o = changed_q & done_q;
  assign pending_any_o    = all_any;

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while busy");

  a_start_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  a_done_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DONE) |=> done_o)
    else $error("missing result strobe");

  a_still_no_calls : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !pending_any_o) |-> (dir_q == DIR_STILL))
    else $error("car moving with no calls pending");

  a_scan_idx : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_APPLY) |=> (idx_q == '0))
    else $error("scan index not cleared");

endmodule

@@ design/els_floor_eval.sv @@
// ----------------------------------------------------------------------------
// els_floor_eval
// Shared compare unit: folds one floor into the running scan results.
// ----------------------------------------------------------------------------
module els_floor_eval (
  input  els_pkg::els_probe_t probe_i,
  input  els_pkg::els_dir_e   dir_i,
  input  els_pkg::floor_t     pos_i,
  input  els_pkg::els_acc_t   acc_i,
  output els_pkg::els_acc_t   acc_o
);
  import els_pkg::*;

  logic   any_call;
  logic   above;
  logic   below;
  floor_t span;

  assign any_call = probe_i.cab | probe_i.up | probe_i.dn;
  assign above    = probe_i.flr > pos_i;
  assign below    = probe_i.flr < pos_i;
  assign span     = above ? (probe_i.flr - pos_i) : (pos_i - probe_i.flr);

  always_comb begin
    acc_o = acc_i;
    if (!probe_i.scan_b) begin
      unique case (dir_i)
        DIR_STILL: begin
          if (any_call && (!acc_i.found || span < acc_i.bestd)) begin
            acc_o.best  = probe_i.flr;
            acc_o.bestd = span;
            acc_o.found = 1'b1;
          end
        end
        DIR_UP: begin
          if (probe_i.dn && above && probe_i.flr > acc_i.limit) begin
            acc_o.limit = probe_i.flr;
          end
        end
        DIR_DOWN: begin
          if (probe_i.up && below && probe_i.flr < acc_i.limit) begin
            acc_o.limit = probe_i.flr;
          end
        end
        default: acc_o = acc_i;
      endcase
    end else begin
      unique case (dir_i)
        DIR_UP: begin
          if ((probe_i.cab || probe_i.up) && above && probe_i.flr < acc_i.limit &&
              probe_i.flr < acc_i.nt) begin
            acc_o.nt = probe_i.flr;
          end
          if (any_call && below) begin
            acc_o.behind = 1'b1;
          end
        end
        DIR_DOWN: begin
          if ((probe_i.cab || probe_i.dn) && below && probe_i.flr > acc_i.limit &&
              probe_i.flr > acc_i.nt) begin
            acc_o.nt = probe_i.flr;
          end
          if (any_call && above) begin
            acc_o.behind = 1'b1;
          end
        end
        default: acc_o = acc_i;
      endcase
    end
  end

endmodule

@@ bench/els_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// els_result_checker
// Watches the command and result channels of the LOOK elevator scheduler,
// keeps its own copy of the call bits and car state, predicts the dispatch
// that each accepted transaction must produce and compares every result
// field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module els_result_checker (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  input  logic            busy,
  input  logic [2:0]      action_i,
  input  els_pkg::floor_t floor_i,
  input  logic            call_dir_i,
  input  logic            done_o,
  input  els_pkg::floor_t dest_floor_o,
  input  logic [1:0]      travel_dir_o,
  input  els_pkg::floor_t travel_limit_o,
  input  logic            target_changed_o,
  input  logic            pending_any_o,
  output int unsigned     mismatch_count_o,
  output int unsigned     outstanding_o
);
  import els_pkg::*;

  typedef struct packed {
    floor_t     target;
    logic [1:0] dir;
    floor_t     limit;
    logic       changed;
    logic       pending;
  } dispatch_t;

  calls_t    cab_r;
  calls_t    up_r;
  calls_t    dn_r;
  int        pos_r;
  int        tgt_r;
  int        lim_r;
  els_dir_e  dir_r;
  dispatch_t dispatch_q[$];

  task automatic report_mismatch(input string what, input int unsigned seen,
                                 input int unsigned want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, seen, want, $realtime);
    mismatch_count_o++;
  endtask

  task automatic plan_route();
    calls_t all;
    int     best;
    int     bestd;
    int     d;
    int     nt;
    bit     behind;
    all = cab_r | up_r | dn_r;
    if (all == '0) begin
      dir_r = DIR_STILL;
      return;
    end
    if (dir_r == DIR_STILL) begin
      best  = 0;
      bestd = 32'hFFFF;
      for (int f = 1; f <= FLOORS; f++) begin
        if (all[f-1]) begin
          d = (f > pos_r) ? f - pos_r : pos_r - f;
          if (d < bestd) begin
            bestd = d;
            best  = f;
          end
        end
      end
      if (best > pos_r) dir_r = DIR_UP;
      else dir_r = DIR_DOWN;
      lim_r = best;
      tgt_r = best;
      return;
    end
    if (dir_r == DIR_UP) begin
      for (int f = pos_r + 1; f <= FLOORS; f++)
        if (dn_r[f-1] && f > lim_r) lim_r = f;
      nt = lim_r;
      for (int f = pos_r + 1; f <= FLOORS; f++)
        if ((cab_r[f-1] || up_r[f-1]) && f < lim_r && f < nt) nt = f;
    end else begin
      for (int f = pos_r - 1; f >= 1; f--)
        if (up_r[f-1] && f < lim_r) lim_r = f;
      nt = lim_r;
      for (int f = pos_r - 1; f >= 1; f--)
        if ((cab_r[f-1] || dn_r[f-1]) && f > lim_r && f > nt) nt = f;
    end
    // at the limit: reverse if anything lies behind, else halt
    if (pos_r == lim_r && pos_r == tgt_r && pos_r == nt) begin
      behind = 1'b0;
      if (dir_r == DIR_UP) begin
        for (int f = 1; f < pos_r; f++)
          if (all[f-1]) behind = 1'b1;
        if (behind) dir_r = DIR_DOWN;
        else dir_r = DIR_STILL;
      end else begin
        for (int f = pos_r + 1; f <= FLOORS; f++)
          if (all[f-1]) behind = 1'b1;
        if (behind) dir_r = DIR_UP;
        else dir_r = DIR_STILL;
      end
    end
    tgt_r = nt;
  endtask

  task automatic predict_dispatch(input logic [2:0] act, input floor_t fl, input logic cdir,
                                  output dispatch_t res);
    int     fi;
    bit     ok;
    bit     changed;
    int     old;
    calls_t bm;
    calls_t pm;
    fi      = int'(fl);
    ok      = (fi >= 1) && (fi <= FLOORS);
    changed = 1'b0;
    bm      = ok ? (calls_t'(1) << (fi - 1)) : '0;
    pm      = calls_t'(1) << (pos_r - 1);
    case (act)
      ACT_CABIN: begin
        if (ok) begin
          cab_r |= bm;
          if (dir_r == DIR_UP && fi > lim_r && fi > pos_r) lim_r = fi;
          else if (dir_r == DIR_DOWN && fi < lim_r && fi < pos_r) lim_r = fi;
          old = tgt_r;
          plan_route();
          changed = (old != tgt_r);
        end
      end
      ACT_HALL: begin
        if (ok) begin
          if (!cdir) up_r |= bm;
          else dn_r |= bm;
          old = tgt_r;
          plan_route();
          changed = (old != tgt_r);
        end
      end
      ACT_POS: begin
        if (ok) pos_r = fi;
      end
      ACT_STOP: begin
        cab_r &= ~pm;
        if (dir_r == DIR_UP) begin
          up_r &= ~pm;
          if (pos_r == lim_r) dn_r &= ~pm;
        end else if (dir_r == DIR_DOWN) begin
          dn_r &= ~pm;
          if (pos_r == lim_r) up_r &= ~pm;
        end else begin
          up_r &= ~pm;
          dn_r &= ~pm;
        end
        plan_route();
      end
      ACT_EVAL: plan_route();
      default: ;
    endcase
    res.target  = floor_t'(tgt_r);
    res.dir     = dir_r;
    res.limit   = floor_t'(lim_r);
    res.changed = changed;
    res.pending = |(cab_r | up_r | dn_r);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    dispatch_t want;
    dispatch_t fresh;
    if (!rst_ni) begin
      cab_r            = '0;
      up_r             = '0;
      dn_r             = '0;
      pos_r            = 1;
      tgt_r            = 1;
      lim_r            = 1;
      dir_r            = DIR_STILL;
      mismatch_count_o = 0;
      dispatch_q.delete();
    end else begin
      if (done_o) begin
        if (dispatch_q.size() == 0) begin
          report_mismatch("unexpected result, target", dest_floor_o, 0);
        end else begin
          want = dispatch_q.pop_front();
          if (dest_floor_o !== want.target)
            report_mismatch("dest_floor", dest_floor_o, want.target);
          if (travel_dir_o !== want.dir)
            report_mismatch("travel_dir", travel_dir_o, want.dir);
          if (travel_limit_o !== want.limit)
            report_mismatch("travel_limit", travel_limit_o, want.limit);
          if (target_changed_o !== want.changed)
            report_mismatch("target_changed", target_changed_o, want.changed);
          if (pending_any_o !== want.pending)
            report_mismatch("pending_any", pending_any_o, want.pending);
        end
      end
      if (start && !busy) begin
        predict_dispatch(action_i, floor_i, call_dir_i, fresh);
        dispatch_q.push_back(fresh);
      end
    end
    outstanding_o = dispatch_q.size();
  end

endmodule

@@ bench/tb_elevator_look_scheduler_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_elevator_look_scheduler_unit
// Drives the LOOK elevator scheduler with a directed opening and then with
// mostly realistic car traffic: calls, one-floor moves toward the reported
// target, stops on arrival, plus some noise. Commands come in bursts with
// random gaps; the checker beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module tb_elevator_look_scheduler_unit;
  import els_pkg::*;

  localparam int unsigned RANDOM_ITEMS = 1530;
  localparam int unsigned DRAIN_LIMIT  = 400;
  localparam int unsigned SETTLE       = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        start;
  logic        busy;
  logic [2:0]  action_i;
  floor_t      floor_i;
  logic        call_dir_i;
  logic        done_o;
  floor_t      dest_floor_o;
  logic [1:0]  travel_dir_o;
  floor_t      travel_limit_o;
  logic        target_changed_o;
  logic        pending_any_o;

  int unsigned mismatch_count;
  int unsigned outstanding;

  int unsigned car_floor;
  floor_t      seen_target;
  bit          pacing;
  int unsigned burst_left;

  elevator_look_scheduler_unit DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .action_i         (action_i),
    .floor_i          (floor_i),
    .call_dir_i       (call_dir_i),
    .done_o           (done_o),
    .dest_floor_o     (dest_floor_o),
    .travel_dir_o     (travel_dir_o),
    .travel_limit_o   (travel_limit_o),
    .target_changed_o (target_changed_o),
    .pending_any_o    (pending_any_o)
  );

  els_result_checker u_check (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .action_i         (action_i),
    .floor_i          (floor_i),
    .call_dir_i       (call_dir_i),
    .done_o           (done_o),
    .dest_floor_o     (dest_floor_o),
    .travel_dir_o     (travel_dir_o),
    .travel_limit_o   (travel_limit_o),
    .target_changed_o (target_changed_o),
    .pending_any_o    (pending_any_o),
    .mismatch_count_o (mismatch_count),
    .outstanding_o    (outstanding)
  );

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // last target reported, steers the car traffic
  always @(posedge clk_i) begin
    if (!rst_ni) seen_target <= floor_t'(1);
    else if (done_o) seen_target <= dest_floor_o;
  end

  task automatic send_cmd(input logic [2:0] act, input floor_t fl, input logic cdir);
    start      <= 1'b1;
    action_i   <= act;
    floor_i    <= fl;
    call_dir_i <= cdir;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (act == ACT_POS && fl >= 1 && fl <= FLOORS) car_floor = fl;
    if (pacing) begin
      if (burst_left > 0) begin
        burst_left--;
      end else begin
        start <= 1'b0;
        if ($urandom_range(0, 9) == 0) repeat ($urandom_range(36, 80)) @(posedge clk_i);
        else repeat ($urandom_range(1, 36)) @(posedge clk_i);
        burst_left = $urandom_range(0, 24);
      end
    end
  endtask

  task automatic random_cmd(output bit counted);
    int unsigned pick;
    logic [2:0]  act;
    floor_t      fl;
    logic        cdir;
    pick    = $urandom_range(0, 99);
    fl      = floor_t'($urandom_range(1, FLOORS));
    cdir    = 1'($urandom_range(0, 1));
    act     = ACT_EVAL;
    if (pick < 40) begin
      // one floor toward the target, stop on arrival
      if (car_floor == seen_target) begin
        act = ACT_STOP;
      end else begin
        act = ACT_POS;
        fl  = (seen_target > car_floor) ? floor_t'(car_floor + 1) : floor_t'(car_floor - 1);
      end
    end else if (pick < 60) begin
      act = ACT_CABIN;
    end else if (pick < 80) begin
      act = ACT_HALL;
    end else if (pick < 88) begin
      act = ACT_EVAL;
    end else if (pick < 92) begin
      act = ACT_STOP;
    end else if (pick < 95) begin
      act = ACT_POS;
    end else begin
      act = 3'($urandom_range(0, 7));
      fl  = floor_t'($urandom_range(0, 31));
    end
    counted = !(act > ACT_EVAL ||
                ((act == ACT_CABIN || act == ACT_HALL || act == ACT_POS) &&
                 (fl < 1 || fl > FLOORS)));
    send_cmd(act, fl, cdir);
  endtask

  initial begin : stimulus
    int unsigned served;
    int unsigned guard;
    bit          counted;
    rst_ni      = 1'b0;
    start       = 1'b0;
    action_i    = ACT_EVAL;
    floor_i     = floor_t'(1);
    call_dir_i  = 1'b0;
    car_floor   = 1;
    pacing      = 1'b0;
    burst_left  = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // tie between two calls at equal distance from a standing car
    send_cmd(ACT_POS,   floor_t'(8), 1'b0);
    send_cmd(ACT_HALL,  floor_t'(8), 1'b1);
    send_cmd(ACT_HALL,  floor_t'(6), 1'b1);
    send_cmd(ACT_POS,   floor_t'(7), 1'b0);
    send_cmd(ACT_EVAL,  floor_t'(7), 1'b0);
    // serve, reverse at the limit, serve again
    send_cmd(ACT_POS,   floor_t'(6), 1'b0);
    send_cmd(ACT_STOP,  floor_t'(6), 1'b0);
    send_cmd(ACT_POS,   floor_t'(8), 1'b0);
    send_cmd(ACT_STOP,  floor_t'(8), 1'b1);
    send_cmd(ACT_EVAL,  floor_t'(8), 1'b1);
    // limit extension, cabin call beyond limit, on-the-way stop
    send_cmd(ACT_POS,   floor_t'(1), 1'b0);
    send_cmd(ACT_CABIN, floor_t'(10), 1'b0);
    send_cmd(ACT_HALL,  floor_t'(14), 1'b1);
    send_cmd(ACT_CABIN, floor_t'(FLOORS), 1'b0);
    send_cmd(ACT_HALL,  floor_t'(3), 1'b0);
    // out of range floors and unknown actions
    send_cmd(ACT_POS,   floor_t'(0), 1'b0);
    send_cmd(ACT_POS,   floor_t'(31), 1'b1);
    send_cmd(ACT_CABIN, floor_t'(0), 1'b0);
    send_cmd(ACT_HALL,  floor_t'(FLOORS + 1), 1'b1);
    for (int a = ACT_EVAL + 1; a < 8; a++) send_cmd(3'(a), floor_t'(5), 1'b1);
    send_cmd(ACT_HALL,  floor_t'(1), 1'b1);
    send_cmd(ACT_HALL,  floor_t'(FLOORS), 1'b0);
    send_cmd(ACT_STOP,  floor_t'(1), 1'b0);

    served = 0;
    pacing = 1'b1;
    while (served < RANDOM_ITEMS) begin
      // one stretch runs back to back
      pacing = !(served >= 600 && served < 750);
      random_cmd(counted);
      if (counted) served++;
    end
    start <= 1'b0;

    guard = 0;
    while (outstanding != 0 && guard < DRAIN_LIMIT) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (SETTLE) @(posedge clk_i);
    if (mismatch_count == 0 && outstanding == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  initial begin : watchdog
    #20000000;
    $display("== FAIL ==");
    $finish;
  end

endmodule

@@ sim.f @@
design/els_pkg.sv
design/els_floor_eval.sv
design/elevator_look_scheduler_unit.sv
bench/els_result_checker.sv
bench/tb_elevator_look_scheduler_unit.sv
